### rtl/utf8v_pkg.sv
// Shared types and byte-class constants for the UTF-8 display text validator.
// No dependencies; imported by utf8v_check and the top level.
`timescale 1ns / 1ps
package utf8v_pkg;

    // Byte classes
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] CTRL_LIMIT    = 8'h20;
    localparam logic [7:0] ASCII_DEL     = 8'h7F;
    localparam logic [7:0] LEAD2_LO      = 8'hC2;
    localparam logic [7:0] LEAD2_HI      = 8'hDF;
    localparam logic [7:0] LEAD3_LO      = 8'hE0;
    localparam logic [7:0] LEAD3_HI      = 8'hEF;
    localparam logic [7:0] LEAD4_LO      = 8'hF0;
    localparam logic [7:0] LEAD4_HI      = 8'hF4;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_TAG      = 8'h80;

    // Codepoint limits
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_C1_LO     = 21'h000080;
    localparam logic [20:0] CP_C1_HI     = 21'h00009F;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_NONCHAR0  = 21'h00FFFE;
    localparam logic [20:0] CP_NONCHAR1  = 21'h00FFFF;
    localparam logic [20:0] CP_MIN2      = 21'h000080;
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;

    localparam int CFG_W = 16;

    // Decode state of one text, apart from the byte count
    typedef struct packed {
        logic        error_seen;
        logic [1:0]  pending;
        logic [20:0] codepoint;
        logic [1:0]  seq_len;
    } text_state_t;

endpackage

### rtl/utf8_display_text_validator.sv
// UTF-8 display text validator: one text byte per cycle, one valid flag per text.
// The final byte is registered at the input, and its result in the result register.
// Throughput: one byte per cycle, set by the single decode pass between the
// input register and the result register; a held result stalls only a final byte.
// Reset (rst_n, async low) clears all text state and loads max_length = 64.
// Depends on utf8v_pkg and utf8v_check.
`timescale 1ns / 1ps
module utf8_display_text_validator
    import utf8v_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
    input  logic              s_axis_tlast,   // final_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] text_valid, [7:1] zero
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data        // max_length
);

    localparam int MASK_BITS = (LENGTH_BITS < CFG_W) ? LENGTH_BITS : CFG_W;
    localparam logic [CFG_W-1:0] LEN_MASK  = CFG_W'((33'd1 << MASK_BITS) - 33'd1);
    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(64) & LEN_MASK;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [CFG_W-1:0]  max_len_reg;
    logic              advance;
    logic              text_ok;

    // a final byte waits only while the previous result is still held
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_ok_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= LEN_RESET;
        else if (cfg_valid)
            max_len_reg <= cfg_data & LEN_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_ok_reg <= text_ok;
    end

    utf8v_check #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .text_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .max_len    (max_len_reg),
        .text_ok    (text_ok)
    );

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready && in_valid_reg && in_last_reg |-> !advance)
        else $error("final byte advanced over a held result");

    a_result_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg)
        else $error("final byte produced no result");

    a_mask_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (max_len_reg & ~LEN_MASK) == '0)
        else $error("max length holds bits beyond the length width");

endmodule

### rtl/utf8v_check.sv
// Per-text decode state and the single-pass byte check.
// Depends on utf8v_pkg; instantiated by utf8_display_text_validator.
`timescale 1ns / 1ps
module utf8v_check
    import utf8v_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        text_byte,
    input  logic              final_byte,
    input  logic [CFG_W-1:0]  max_len,
    output logic              text_ok
);

    localparam int CNT_W = LENGTH_BITS + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    text_state_t            state_reg;
    text_state_t            state_next;
    text_state_t            decoded;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_inc;
    logic [20:0]            cp_shift;
    logic                   cp_bad;

    assign count_inc = (&count_reg) ? count_reg : count_reg + CNT_W'(1);
    assign cp_shift  = {state_reg.codepoint[14:0], text_byte[5:0]};

    // Range and overlong checks on the completed codepoint
    always_comb
    begin
        cp_bad = 1'b0;
        if ((cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
            (cp_shift >= CP_C1_LO && cp_shift <= CP_C1_HI) ||
            cp_shift > CP_MAX || cp_shift == CP_NONCHAR0 || cp_shift == CP_NONCHAR1)
            cp_bad = 1'b1;
        if (cp_shift < CP_MIN2 ||
            (cp_shift < CP_MIN3 && state_reg.seq_len >= 2'd2) ||
            (cp_shift < CP_MIN4 && state_reg.seq_len == 2'd3))
            cp_bad = 1'b1;
    end

    always_comb
    begin
        decoded = state_reg;
        if (state_reg.pending == 2'd0)
        begin
            if (text_byte < ASCII_LIMIT)
            begin
                if (text_byte < CTRL_LIMIT || text_byte == ASCII_DEL)
                    decoded.error_seen = 1'b1;
            end
            else if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI)
            begin
                decoded.codepoint = {16'd0, text_byte[4:0]};
                decoded.seq_len   = 2'd1;
                decoded.pending   = 2'd1;
            end
            else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI)
            begin
                decoded.codepoint = {17'd0, text_byte[3:0]};
                decoded.seq_len   = 2'd2;
                decoded.pending   = 2'd2;
            end
            else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI)
            begin
                decoded.codepoint = {18'd0, text_byte[2:0]};
                decoded.seq_len   = 2'd3;
                decoded.pending   = 2'd3;
            end
            else
                decoded.error_seen = 1'b1;
        end
        else if ((text_byte & CONT_MASK) != CONT_TAG)
        begin
            // drop the broken sequence
            decoded.error_seen = 1'b1;
            decoded.pending    = 2'd0;
            decoded.codepoint  = 21'd0;
            decoded.seq_len    = 2'd0;
        end
        else
        begin
            decoded.codepoint = cp_shift;
            decoded.pending   = state_reg.pending - 2'd1;
            if (state_reg.pending == 2'd1 && cp_bad)
                decoded.error_seen = 1'b1;
        end
    end

    assign text_ok = !decoded.error_seen && decoded.pending == 2'd0 &&
                     CMP_W'(count_inc) <= CMP_W'(max_len);

    always_comb
    begin
        state_next = decoded;
        count_next = count_inc;
        if (final_byte)
        begin
            state_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        advance && final_byte |=> state_reg == '0 && count_reg == '0)
        else $error("text state not cleared after final byte");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending <= state_reg.seq_len)
        else $error("pending continuations exceed sequence length");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !final_byte && (&count_reg) |=> (&count_reg))
        else $error("byte count wrapped");

endmodule

### bench/utf8_display_text_validator_tb.sv
// Self-checking bench for utf8_display_text_validator: streams texts byte by byte and
// checks each valid flag against a built-in model of the UTF-8 display text rules.
// Depends on utf8v_pkg and the validator RTL.
`timescale 1ns / 1ps
module utf8_display_text_validator_tb;
    import utf8v_pkg::*;

    localparam int LEN_BITS    = 16;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] text_byte
    logic              s_axis_tlast;   // final_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [0] text_valid, [7:1] zero
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;       // max_length

    // Model of the block: decode state, byte count and the length register
    text_state_t       dec;
    logic [LEN_BITS:0] seen_bytes;
    logic [15:0]       limit_bytes;

    logic              verdict_q[$];
    logic [7:0]        text_buf[$];
    int                fail_count;
    bit                tx_calm;
    bit                rx_calm;
    int                hold_req;

    utf8_display_text_validator #(
        .LENGTH_BITS(LEN_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the model by one accepted byte; queue the verdict on the final byte
    task automatic track_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        logic        ok;
        if (seen_bytes != '1)
            seen_bytes = seen_bytes + 1'b1;
        if (dec.pending == 2'd0)
        begin
            if (b < ASCII_LIMIT)
            begin
                if (b < CTRL_LIMIT || b == ASCII_DEL)
                    dec.error_seen = 1'b1;
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                dec.codepoint = {16'd0, b[4:0]};
                dec.seq_len   = 2'd1;
                dec.pending   = 2'd1;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                dec.codepoint = {17'd0, b[3:0]};
                dec.seq_len   = 2'd2;
                dec.pending   = 2'd2;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                dec.codepoint = {18'd0, b[2:0]};
                dec.seq_len   = 2'd3;
                dec.pending   = 2'd3;
            end
            else
                dec.error_seen = 1'b1;
        end
        else if ((b & CONT_MASK) != CONT_TAG)
        begin
            // Drop the broken sequence; this byte is not decoded again
            dec.error_seen = 1'b1;
            dec.pending    = 2'd0;
            dec.codepoint  = '0;
            dec.seq_len    = 2'd0;
        end
        else
        begin
            dec.codepoint = {dec.codepoint[14:0], b[5:0]};
            dec.pending   = dec.pending - 2'd1;
            if (dec.pending == 2'd0)
            begin
                cp = dec.codepoint;
                if ((cp >= CP_SURR_LO && cp <= CP_SURR_HI) || (cp >= CP_C1_LO && cp <= CP_C1_HI)
                        || cp > CP_MAX || cp == CP_NONCHAR0 || cp == CP_NONCHAR1)
                    dec.error_seen = 1'b1;
                if (cp < CP_MIN2 || (cp < CP_MIN3 && dec.seq_len >= 2'd2)
                        || (cp < CP_MIN4 && dec.seq_len == 2'd3))
                    dec.error_seen = 1'b1;
            end
        end
        if (fin)
        begin
            ok = !dec.error_seen && dec.pending == 2'd0 && seen_bytes <= {1'b0, limit_bytes};
            verdict_q.push_back(ok);
            dec        = '0;
            seen_bytes = '0;
        end
    endtask

    // Offer one byte; valid stays high after the request so back-to-back bytes need no gap
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        track_byte(b, fin);
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_run(input int count, input logic [7:0] b);
        for (int i = 0; i < count; i++)
            send_byte(b, i == count - 1);
    endtask

    // Drop valid and wait until every verdict is back and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        limit_bytes = value;
    endtask

    task automatic put_cp(input logic [20:0] cp, input int n);
        case (n)
            1: text_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                text_buf.push_back({3'b110, cp[10:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_buf.push_back({4'b1110, cp[15:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_buf.push_back({5'b11110, cp[20:18]});
                text_buf.push_back({2'b10, cp[17:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed text with random content, salted with broken and illegal pieces
    task automatic build_text();
        int          nchars;
        int          n;
        int          r;
        logic [20:0] cp;
        text_buf.delete();
        nchars = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
        for (int i = 0; i < nchars; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                put_cp(21'($urandom_range(32'h20, 32'h7E)), 1);
            else if (r < 62)
                put_cp(21'($urandom_range(32'hA0, 32'h7FF)), 2);
            else if (r < 74)
            begin
                cp = 21'($urandom_range(32'h800, 32'hFFFD));
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                    cp = cp - 21'h1000;
                put_cp(cp, 3);
            end
            else if (r < 82)
                put_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            else if (r < 86)
                text_buf.push_back(8'($urandom_range(0, 255)));
            else if (r < 89)
                put_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
            else if (r < 91)
                put_cp(21'($urandom_range(32'h80, 32'h9F)), 2);
            else if (r < 93)
            begin
                n = $urandom_range(2, 4);
                cp = 21'($urandom_range(0, (n == 2) ? 32'h7F : (n == 3) ? 32'h7FF : 32'hFFFF));
                put_cp(cp, n);
            end
            else if (r < 95)
                put_cp(21'($urandom_range(32'h110000, 32'h13FFFF)), 4);
            else if (r < 96)
                put_cp(21'($urandom_range(32'hFFFE, 32'hFFFF)), 3);
            else if (r < 98)
            begin
                n = $urandom_range(3, 4);
                put_cp((n == 3) ? 21'h4E2D : 21'h1F600, n);
                repeat ($urandom_range(1, n - 1)) void'(text_buf.pop_back());
            end
            else
                text_buf.push_back(($urandom_range(0, 3) == 0) ? ASCII_DEL
                                                                : 8'($urandom_range(0, 31)));
        end
        if (text_buf.size() == 0)
            text_buf.push_back(8'h41);
    endtask

    task automatic test_directed();
        text_buf = '{8'h41};                    send_text();  // plain ASCII
        text_buf = '{8'h00};                    send_text();  // control byte
        text_buf = '{ASCII_DEL};                send_text();
        text_buf = '{8'hC1};                    send_text();  // illegal lead, low end
        text_buf = '{8'hFF};                    send_text();  // illegal lead, high end
        text_buf = '{8'hC2, 8'hA0};             send_text();  // smallest legal 2-byte
        text_buf = '{8'hC2, 8'h80};             send_text();  // C1 control
        text_buf = '{8'hE0, 8'h80, 8'h80};      send_text();  // overlong
        text_buf = '{8'hED, 8'hA0, 8'h80};      send_text();  // surrogate
        text_buf = '{8'hEF, 8'hBF, 8'hBF};      send_text();  // noncharacter
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text(); // above U+10FFFF
        text_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_text(); // legal 4-byte
        text_buf = '{8'hE2, 8'h41};             send_text();  // broken sequence
        text_buf = '{8'hC3};                    send_text();  // cut off at the end
        settle();
    endtask

    task automatic test_length_limit();
        write_max_length(16'd0);
        send_run(1, 8'h41);
        write_max_length(16'd5);
        send_run(5, 8'h41);
        send_run(6, 8'h41);
        text_buf = '{8'hC2, 8'hA0, 8'hC2, 8'hA0, 8'h41};
        send_text();
        write_max_length(16'd64);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_run(64, 8'h41);
        send_run(65, 8'h41);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
    endtask

    task automatic test_backpressure();
        write_max_length(16'd64);
        hold_req = 400;
        tx_calm  = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            build_text();
            send_text();
        end
        tx_calm = 1'b0;
        settle();
    endtask

    task automatic test_random_texts(input logic [15:0] max_len, input int byte_budget);
        int sent;
        sent = 0;
        write_max_length(max_len);
        while (sent < byte_budget)
        begin
            tx_calm = ($urandom_range(0, 5) == 0);
            rx_calm = tx_calm;
            build_text();
            sent += text_buf.size();
            send_text();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
    endtask

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual tdata=%h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_axis_tdata !== {7'd0, want})
                begin
                    $display("%0t: text_valid mismatch, expected tdata=%h actual tdata=%h",
                             $time, {7'd0, want}, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0 && !rx_calm)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        fail_count    = 0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        hold_req      = 0;
        dec           = '0;
        seen_bytes    = '0;
        limit_bytes   = 16'd64;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_length_limit();
        test_backpressure();
        test_random_texts(16'd64, 250);
        test_random_texts(16'd1, 250);
        test_random_texts(16'd9, 250);
        test_random_texts(16'd30, 250);
        test_random_texts(16'd200, 250);
        test_random_texts(16'hFFFF, 250);

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
